@@ design/sliding_window_trend_stats_macros.svh @@
// ----------------------------------------------------------------------------
// Sliding window trend stats assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_TREND_STATS_MACROS_SVH
`define SLIDING_WINDOW_TREND_STATS_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define SWTS_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define SWTS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/swts_pkg.sv @@
// ----------------------------------------------------------------------------
// swts_pkg
// Types, widths and constants shared by the trend statistics modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swts_pkg;

    localparam int W_SAMPLE = 32;
    localparam int W_WIN    = 8;
    localparam int W_S1     = 40;
    localparam int W_SQ     = 64;
    localparam int W_S2     = 72;
    localparam int W_ACC    = 40;
    localparam int W_PROD   = 80;
    localparam int W_MB     = 40;
    localparam int W_ROOT   = 40;
    localparam int W_DVD    = 41;
    localparam int W_DVS    = 33;
    localparam int W_AN     = 40;

    localparam logic [W_DVD-1:0] PCT_POS_MAX = W_DVD'(64'd2147483646);
    localparam logic [W_DVD-1:0] PCT_NEG_MAX = W_DVD'(64'd2147483647);
    localparam logic [6:0]       PCT_SCALE   = 7'd100;

    typedef enum logic [1:0] {
        STAT_NONE     = 2'd0,
        STAT_DEV      = 2'd1,
        STAT_ALL      = 2'd2,
        STAT_OLD_ZERO = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SIGN_ZERO    = 2'd0,
        SIGN_POS     = 2'd1,
        SIGN_NEG     = 2'd2,
        SIGN_UNKNOWN = 2'd3
    } t_sign;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_MT_GO,
        ST_MT_WAIT,
        ST_MD_GO,
        ST_MD_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_DS_GO,
        ST_DS_WAIT,
        ST_DG_GO,
        ST_DG_WAIT,
        ST_PCT_PREP,
        ST_DP_GO,
        ST_DP_WAIT,
        ST_OUT
    } t_state;

    // Clamp a quotient to the 32-bit unsigned range
    function automatic logic [31:0] sat32(input logic [W_DVD-1:0] v);
        logic [31:0] r;
        begin
            r = (v[W_DVD-1:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ design/swts_ring.sv @@
// ----------------------------------------------------------------------------
// swts_ring
// Sample ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module swts_ring
    import swts_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire logic [W_SAMPLE-1:0] i_wdata,
    input  wire logic                i_re,
    input  wire logic [AW-1:0]       i_raddr,
    output logic      [W_SAMPLE-1:0] o_rdata
);

    logic [W_SAMPLE-1:0] r_mem [DEPTH];

    // Write the new sample
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/swts_mul.sv @@
// ----------------------------------------------------------------------------
// swts_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swts_mul
    import swts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W_PROD-1:0] i_a,
    input  wire logic [W_MB-1:0]   i_b,
    output logic                   o_busy,
    output logic      [W_PROD-1:0] o_p
);

    localparam int CW = $clog2(W_MB + 1);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [W_PROD-1:0] r_a;
    logic [W_MB-1:0]   r_b;
    logic [W_PROD-1:0] r_p;

    // Count the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W_MB);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Add the shifted multiplicand for each set bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= {r_a[W_PROD-2:0], 1'b0};
            r_b <= {1'b0, r_b[W_MB-1:1]};
        end
    end

    assign o_busy = r_busy;
    assign o_p    = r_p;

endmodule

`default_nettype wire

@@ design/swts_sqrt.sv @@
// ----------------------------------------------------------------------------
// swts_sqrt
// Digit-by-digit integer square root, one root bit per cycle, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module swts_sqrt
    import swts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W_PROD-1:0] i_rad,
    output logic                   o_busy,
    output logic      [W_ROOT-1:0] o_root
);

    localparam int CW = $clog2(W_ROOT + 1);
    localparam int RW = W_ROOT + 4;

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [W_PROD-1:0] r_rad;
    logic [RW-1:0]     r_rem;
    logic [W_ROOT-1:0] r_root;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic              fits;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        rem_sh = {r_rem[RW-3:0], r_rad[W_PROD-1 -: 2]};
        trial  = RW'({r_root, 2'b01});
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W_ROOT);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[W_PROD-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[W_ROOT-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ design/swts_div.sv @@
// ----------------------------------------------------------------------------
// swts_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swts_div
    import swts_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [W_DVD-1:0] i_num,
    input  wire logic [W_DVS-1:0] i_den,
    output logic                  o_busy,
    output logic      [W_DVD-1:0] o_q
);

    localparam int CW = $clog2(W_DVD + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [W_DVD-1:0] r_num;
    logic [W_DVS:0]   r_rem;
    logic [W_DVS-1:0] r_den;
    logic [W_DVS:0]   rem_sh;
    logic             ge;

    // Shift in the next dividend bit and compare
    always_comb begin
        rem_sh = {r_rem[W_DVS-1:0], r_num[W_DVD-1]};
        ge     = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(W_DVD);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Quotient bits replace dividend bits from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_num <= {r_num[W_DVD-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_num;

endmodule

`default_nettype wire

@@ design/sliding_window_trend_stats.sv @@
// Rolling statistics over signed Q16.16 samples. Each request stores its sample in a
// ring memory and yields one result: once n samples are held, the truncated population
// standard deviation of the newest n samples and, once n+1 samples are held, the mean
// positive step and the rounded percent change against the sample n back, if nonzero
// (n = window_length, clamped to MAX_WINDOW - 1 and 255). One request is handled at a
// time: n or n+1 ring reads at one per cycle through the single read port, then a
// shared shift-add multiplier (two products), a bit-serial square root and a shared
// divider (up to three quotients), each with a start state and a wait state.
// Configuration writes are taken at any time, and belong between requests only.
// ----------------------------------------------------------------------------
// sliding_window_trend_stats
// Top level: ring control, window accumulation, sequencer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_trend_stats_macros.svh"

module sliding_window_trend_stats
    import swts_pkg::*;
#(
    parameter int MAX_WINDOW = 256
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [W_WIN-1:0]    i_cfg_window_length,
    input  wire logic                i_sample_valid,
    output logic                     o_sample_ready,
    input  wire logic [W_SAMPLE-1:0] i_sample,
    output logic                     o_result_valid,
    input  wire logic                i_result_ready,
    output logic      [1:0]          o_status,
    output logic      [31:0]         o_std_deviation,
    output logic      [31:0]         o_mean_gain,
    output logic      [31:0]         o_percent_change,
    output logic                     o_switch_now,
    output logic      [31:0]         o_switch_total
);

    localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int AW1  = AW + 1;
    localparam int SW   = $clog2(MAX_WINDOW + 1);
    localparam int CW   = (SW > W_WIN + 1) ? SW : W_WIN + 1;
    localparam int NMAX = (MAX_WINDOW - 1 < 255) ? MAX_WINDOW - 1 : 255;

    t_state r_state, n_state;

    logic [W_WIN-1:0]    r_window_length;
    logic [AW-1:0]       r_head;
    logic [SW-1:0]       r_seen;
    t_sign               r_last_sign;
    logic [31:0]         r_switch_count;

    logic [AW-1:0]       r_base;
    logic [W_WIN-1:0]    r_n;
    logic [W_WIN-1:0]    r_last;
    logic [W_WIN-1:0]    r_k;
    logic                r_do_gain;
    logic                r_drain;

    logic                r_rd_vld;
    logic [W_WIN-1:0]    r_rd_k;
    logic [W_S1-1:0]     r_s1;
    logic [W_SQ-1:0]     r_sq;
    logic                r_sq_vld;
    logic [W_S2-1:0]     r_s2;
    logic [W_ACC-1:0]    r_acc;
    logic [W_SAMPLE-1:0] r_prev;
    logic [W_SAMPLE-1:0] r_new;
    logic [W_SAMPLE-1:0] r_old;

    logic [W_PROD-1:0]   r_t;
    logic [W_PROD-1:0]   r_var;
    logic [W_AN-1:0]     r_an;
    logic                r_dneg;

    t_status             r_status;
    logic [31:0]         r_std;
    logic [31:0]         r_gain;
    logic [31:0]         r_pct;
    logic                r_sw;

    logic                r_o_valid;
    logic [1:0]          r_o_status;
    logic [31:0]         r_o_std;
    logic [31:0]         r_o_gain;
    logic [31:0]         r_o_pct;
    logic                r_o_sw;
    logic [31:0]         r_o_total;

    logic                sample_acc;
    logic                out_load;
    logic [W_WIN-1:0]    n_clamp;
    logic [SW-1:0]       n_seen;
    logic                n_do_std;
    logic                n_do_gain;
    logic [AW1-1:0]      rd_diff;
    logic [AW-1:0]       rd_addr;
    logic [W_SAMPLE-1:0] rd_data;
    logic [W_SAMPLE-1:0] x_mag;
    logic [W_SAMPLE:0]   step;
    logic [W_S1-1:0]     s1_mag;
    logic [W_SAMPLE:0]   dlt;
    logic [W_SAMPLE:0]   dlt_mag;
    logic [W_SAMPLE-1:0] old_mag;

    logic                mul_start, sq_start, div_start;
    logic [W_PROD-1:0]   mul_a, mul_p;
    logic [W_MB-1:0]     mul_b;
    logic                mul_busy, sq_busy, div_busy;
    logic [W_ROOT-1:0]   sq_root;
    logic [W_DVD-1:0]    div_num, div_q;
    logic [W_DVS-1:0]    div_den;

    logic                pct_neg;
    logic [31:0]         pct_val;
    t_sign               pct_sign;

    // Handshakes
    assign o_cfg_ready    = 1'b1;
    assign o_sample_ready = (r_state == ST_IDLE);
    assign sample_acc     = i_sample_valid && o_sample_ready;
    assign out_load       = (r_state == ST_OUT) && (!r_o_valid || i_result_ready);

    // Hold the window length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= W_WIN'(7);
        end else if (i_cfg_valid) begin
            r_window_length <= i_cfg_window_length;
        end
    end

    // Decode the new request against the fill level
    always_comb begin
        n_clamp   = (r_window_length > W_WIN'(NMAX)) ? W_WIN'(NMAX) : r_window_length;
        n_seen    = (r_seen < SW'(MAX_WINDOW)) ? r_seen + 1'b1 : r_seen;
        n_do_std  = (n_clamp != '0) && (CW'(n_seen) >= CW'(n_clamp));
        n_do_gain = n_do_std && (CW'(n_seen) >= CW'(n_clamp) + 1'b1);
    end

    // Ring address of the sample k places back from the newest
    always_comb begin
        rd_diff = {1'b0, r_base} - AW1'(r_k);
        rd_addr = rd_diff[AW] ? AW'(rd_diff + AW1'(MAX_WINDOW)) : rd_diff[AW-1:0];
    end

    swts_ring #(
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (sample_acc),
        .i_waddr (r_head),
        .i_wdata (i_sample),
        .i_re    (r_state == ST_READ),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Ring pointer, fill count, sign history and switch count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_seen         <= '0;
            r_last_sign    <= SIGN_UNKNOWN;
            r_switch_count <= '0;
        end else begin
            if (sample_acc) begin
                r_head <= (r_head == AW'(MAX_WINDOW - 1)) ? '0 : r_head + 1'b1;
                r_seen <= n_seen;
            end
            if (r_state == ST_DP_WAIT && !div_busy) begin
                r_last_sign <= pct_sign;
                if (r_last_sign != SIGN_UNKNOWN && pct_sign != r_last_sign) begin
                    r_switch_count <= r_switch_count + 1'b1;
                end
            end
        end
    end

    // Per-sample terms
    always_comb begin
        x_mag   = rd_data[W_SAMPLE-1] ? (~rd_data + 1'b1) : rd_data;
        step    = {r_prev[W_SAMPLE-1], r_prev} - {rd_data[W_SAMPLE-1], rd_data};
        s1_mag  = r_s1[W_S1-1] ? (~r_s1 + 1'b1) : r_s1;
        dlt     = {r_new[W_SAMPLE-1], r_new} - {r_old[W_SAMPLE-1], r_old};
        dlt_mag = dlt[W_SAMPLE] ? (~dlt + 1'b1) : dlt;
        old_mag = r_old[W_SAMPLE-1] ? (~r_old + 1'b1) : r_old;
    end

    // Read pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_sq_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == ST_READ);
            r_sq_vld <= r_rd_vld && (r_rd_k < r_n);
        end
    end

    // Accumulate sums, squares and positive steps over the window
    always_ff @(posedge i_clk) begin
        r_rd_k <= r_k;
        if (sample_acc) begin
            r_s1  <= '0;
            r_s2  <= '0;
            r_acc <= '0;
        end else begin
            if (r_rd_vld) begin
                if (r_rd_k < r_n) begin
                    r_s1 <= r_s1 + W_S1'($signed(rd_data));
                end
                r_sq <= W_SQ'(x_mag) * W_SQ'(x_mag);
                if (r_rd_k != '0 && !step[W_SAMPLE] && step != '0) begin
                    r_acc <= r_acc + W_ACC'(step[W_SAMPLE-1:0]);
                end
                r_prev <= rd_data;
                r_old  <= rd_data;
                if (r_rd_k == '0) begin
                    r_new <= rd_data;
                end
            end
            if (r_sq_vld) begin
                r_s2 <= r_s2 + W_S2'(r_sq);
            end
        end
    end

    // Percent: round half away from zero, then saturate
    always_comb begin
        pct_neg = (r_dneg != r_old[W_SAMPLE-1]) && (div_q != '0);
        if (pct_neg) begin
            pct_val  = (div_q > PCT_NEG_MAX) ? (~PCT_NEG_MAX[31:0] + 1'b1)
                                             : (~div_q[31:0] + 1'b1);
            pct_sign = SIGN_NEG;
        end else begin
            pct_val  = (div_q > PCT_POS_MAX) ? PCT_POS_MAX[31:0] : div_q[31:0];
            pct_sign = (div_q != '0) ? SIGN_POS : SIGN_ZERO;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state and unit requests
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        sq_start  = 1'b0;
        div_start = 1'b0;
        mul_a     = W_PROD'(r_s2);
        mul_b     = W_MB'(r_n);
        div_num   = W_DVD'(sq_root);
        div_den   = W_DVS'(r_n);
        unique case (r_state)
            ST_IDLE: begin
                if (sample_acc) begin
                    n_state = n_do_std ? ST_READ : ST_OUT;
                end
            end
            ST_READ: begin
                if (r_k == r_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain) begin
                    n_state = ST_MT_GO;
                end
            end
            ST_MT_GO: begin
                mul_start = 1'b1;
                n_state   = ST_MT_WAIT;
            end
            ST_MT_WAIT: begin
                if (!mul_busy) begin
                    n_state = ST_MD_GO;
                end
            end
            ST_MD_GO: begin
                mul_start = 1'b1;
                mul_a     = W_PROD'(s1_mag);
                mul_b     = s1_mag;
                n_state   = ST_MD_WAIT;
            end
            ST_MD_WAIT: begin
                if (!mul_busy) begin
                    n_state = ST_SQ_GO;
                end
            end
            ST_SQ_GO: begin
                sq_start = 1'b1;
                n_state  = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (!sq_busy) begin
                    n_state = ST_DS_GO;
                end
            end
            ST_DS_GO: begin
                div_start = 1'b1;
                n_state   = ST_DS_WAIT;
            end
            ST_DS_WAIT: begin
                if (!div_busy) begin
                    n_state = r_do_gain ? ST_DG_GO : ST_OUT;
                end
            end
            ST_DG_GO: begin
                div_start = 1'b1;
                div_num   = W_DVD'(r_acc);
                n_state   = ST_DG_WAIT;
            end
            ST_DG_WAIT: begin
                if (!div_busy) begin
                    n_state = (r_old == '0) ? ST_OUT : ST_PCT_PREP;
                end
            end
            ST_PCT_PREP: begin
                n_state = ST_DP_GO;
            end
            ST_DP_GO: begin
                div_start = 1'b1;
                div_num   = W_DVD'({r_an, 1'b0}) + W_DVD'(old_mag);
                div_den   = {old_mag, 1'b0};
                n_state   = ST_DP_WAIT;
            end
            ST_DP_WAIT: begin
                if (!div_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Per-request working registers
    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_base    <= r_head;
            r_n       <= n_clamp;
            r_last    <= n_do_gain ? n_clamp : n_clamp - 1'b1;
            r_do_gain <= n_do_gain;
            r_k       <= '0;
            r_drain   <= 1'b0;
            r_status  <= n_do_std ? STAT_DEV : STAT_NONE;
            r_std     <= '0;
            r_gain    <= '0;
            r_pct     <= '0;
            r_sw      <= 1'b0;
        end else begin
            if (r_state == ST_READ) begin
                r_k <= r_k + 1'b1;
            end
            if (r_state == ST_DRAIN) begin
                r_drain <= 1'b1;
            end
            if (r_state == ST_MT_WAIT && !mul_busy) begin
                r_t <= mul_p;
            end
            if (r_state == ST_MD_WAIT && !mul_busy) begin
                r_var <= (r_t < mul_p) ? '0 : r_t - mul_p;
            end
            if (r_state == ST_DS_WAIT && !div_busy) begin
                r_std <= sat32(div_q);
            end
            if (r_state == ST_DG_WAIT && !div_busy) begin
                r_gain <= sat32(div_q);
                if (r_old == '0) begin
                    r_status <= STAT_OLD_ZERO;
                end
            end
            if (r_state == ST_PCT_PREP) begin
                r_an   <= W_AN'(dlt_mag) * W_AN'(PCT_SCALE);
                r_dneg <= dlt[W_SAMPLE];
            end
            if (r_state == ST_DP_WAIT && !div_busy) begin
                r_status <= STAT_ALL;
                r_pct    <= pct_val;
                r_sw     <= (r_last_sign != SIGN_UNKNOWN) && (pct_sign != r_last_sign);
            end
        end
    end

    swts_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_p     (mul_p)
    );

    swts_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_var),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    swts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_q     (div_q)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid  <= 1'b0;
            r_o_status <= '0;
            r_o_std    <= '0;
            r_o_gain   <= '0;
            r_o_pct    <= '0;
            r_o_sw     <= 1'b0;
            r_o_total  <= '0;
        end else if (out_load) begin
            r_o_valid  <= 1'b1;
            r_o_status <= r_status;
            r_o_std    <= r_std;
            r_o_gain   <= r_gain;
            r_o_pct    <= r_pct;
            r_o_sw     <= r_sw;
            r_o_total  <= r_switch_count;
        end else if (i_result_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_result_valid   = r_o_valid;
    assign o_status         = r_o_status;
    assign o_std_deviation  = r_o_std;
    assign o_mean_gain      = r_o_gain;
    assign o_percent_change = r_o_pct;
    assign o_switch_now     = r_o_sw;
    assign o_switch_total   = r_o_total;

    // Checks
    `SWTS_CHECK_NOW(a_idle_units, sample_acc, !mul_busy && !sq_busy && !div_busy, "unit busy at request")
    `SWTS_CHECK_NOW(a_none_zero, o_result_valid && o_status == STAT_NONE, o_std_deviation == '0 && o_mean_gain == '0 && o_percent_change == '0, "fields set without window")
    `SWTS_CHECK_NOW(a_switch_status, o_switch_now, o_status == STAT_ALL, "switch without percent")
    `SWTS_CHECK_NEXT(a_total_step, out_load && !r_sw, o_switch_total == $past(r_o_total) || o_switch_total == $past(r_switch_count), "switch total moved without switch")

endmodule

`default_nettype wire
